### hdl/lmfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmfs_pkg;

    localparam int unsigned LMFS_LED_COUNT = 25;
    localparam int unsigned LMFS_LED_W     = 5;
    localparam int unsigned LMFS_ROW_W     = 2;
    localparam int unsigned LMFS_COL_W     = 9;
    localparam int unsigned LMFS_IDX_W     = 8;
    localparam int unsigned LMFS_SYM_W     = 25;

    typedef enum logic [2:0] {
        CMD_DOT_ON  = 3'd0,
        CMD_DOT_OFF = 3'd1,
        CMD_DOT_SET = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_LOAD    = 3'd4,
        CMD_TICK    = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_EXEC,
        ST_SYM,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic                  clear_all;
        logic                  wr_en;
        logic                  lit;
        logic [LMFS_ROW_W-1:0] row;
        logic [LMFS_COL_W-1:0] mask;
    } t_frame_op;

    // electrical row of each logical LED
    function automatic logic [LMFS_ROW_W-1:0] led_row(input logic [LMFS_LED_W-1:0] n);
        logic [LMFS_ROW_W-1:0] r;
        case (n)
            5'd0:    r = 2'd0;
            5'd1:    r = 2'd1;
            5'd2:    r = 2'd0;
            5'd3:    r = 2'd1;
            5'd4:    r = 2'd0;
            5'd5:    r = 2'd2;
            5'd6:    r = 2'd2;
            5'd7:    r = 2'd2;
            5'd8:    r = 2'd2;
            5'd9:    r = 2'd2;
            5'd10:   r = 2'd1;
            5'd11:   r = 2'd0;
            5'd12:   r = 2'd1;
            5'd13:   r = 2'd2;
            5'd14:   r = 2'd1;
            5'd15:   r = 2'd0;
            5'd16:   r = 2'd0;
            5'd17:   r = 2'd0;
            5'd18:   r = 2'd0;
            5'd19:   r = 2'd0;
            5'd20:   r = 2'd2;
            5'd21:   r = 2'd1;
            5'd22:   r = 2'd2;
            5'd23:   r = 2'd1;
            5'd24:   r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // column bit of each logical LED
    function automatic logic [LMFS_COL_W-1:0] led_mask(input logic [LMFS_LED_W-1:0] n);
        logic [LMFS_COL_W-1:0] m;
        case (n)
            5'd0:    m = 9'd1;
            5'd1:    m = 9'd8;
            5'd2:    m = 9'd2;
            5'd3:    m = 9'd16;
            5'd4:    m = 9'd4;
            5'd5:    m = 9'd8;
            5'd6:    m = 9'd16;
            5'd7:    m = 9'd32;
            5'd8:    m = 9'd64;
            5'd9:    m = 9'd128;
            5'd10:   m = 9'd2;
            5'd11:   m = 9'd256;
            5'd12:   m = 9'd4;
            5'd13:   m = 9'd256;
            5'd14:   m = 9'd1;
            5'd15:   m = 9'd128;
            5'd16:   m = 9'd64;
            5'd17:   m = 9'd32;
            5'd18:   m = 9'd16;
            5'd19:   m = 9'd8;
            5'd20:   m = 9'd4;
            5'd21:   m = 9'd64;
            5'd22:   m = 9'd1;
            5'd23:   m = 9'd32;
            5'd24:   m = 9'd2;
            default: m = 9'd0;
        endcase
        return m;
    endfunction

    // subtrahend for each step of the modulo-25 reduction: 200, 100, 50, 25
    function automatic logic [LMFS_IDX_W-1:0] mod_step_k(input logic [1:0] step);
        logic [LMFS_IDX_W-1:0] k;
        case (step)
            2'd0:    k = LMFS_IDX_W'(LMFS_LED_COUNT * 8);
            2'd1:    k = LMFS_IDX_W'(LMFS_LED_COUNT * 4);
            2'd2:    k = LMFS_IDX_W'(LMFS_LED_COUNT * 2);
            default: k = LMFS_IDX_W'(LMFS_LED_COUNT);
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### hdl/lmfs_frame.sv
`timescale 1ns / 1ps
`default_nettype none

module lmfs_frame #(
    parameter int ELEC_ROWS = 3,
    parameter int ELEC_COLS = 9
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  lmfs_pkg::t_frame_op   i_op,
    input  wire  [lmfs_pkg::LMFS_ROW_W-1:0] i_rd_row,
    output logic [ELEC_COLS-1:0]        o_rd_data
);
    import lmfs_pkg::*;

    logic [ELEC_COLS-1:0] r_rows [ELEC_ROWS];
    logic [ELEC_COLS-1:0] w_mask;

    assign w_mask = i_op.mask[ELEC_COLS-1:0];

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < ELEC_ROWS; r++) begin
            if (!i_rst_n || i_op.clear_all) begin
                r_rows[r] <= '0;
            end else if (i_op.wr_en && i_op.row == LMFS_ROW_W'(r)) begin
                if (i_op.lit) begin
                    r_rows[r] <= r_rows[r] | w_mask;
                end else begin
                    r_rows[r] <= r_rows[r] & ~w_mask;
                end
            end
        end
    end

    always_comb begin
        o_rd_data = '0;
        for (int r = 0; r < ELEC_ROWS; r++) begin
            if (i_rd_row == LMFS_ROW_W'(r)) begin
                o_rd_data = r_rows[r];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/led_matrix_frame_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow from acceptance to the o_done strobe: clear, tick and unused codes pass ST_EXEC and
// ST_REPLY; dot commands first pass ST_MOD for the four compare/subtract steps of the
// modulo-25 reduction; symbol load passes ST_EXEC, then ST_SYM (one LED per cycle through
// the table), then ST_REPLY. One transaction at a time: busy drops with o_done, so the next
// one can be accepted on the edge that takes the strobe; no receiver stall.
// Synchronous active-low reset darkens the frame, stops row drive, sets columns high.
module led_matrix_frame_scanner #(
    parameter int ELEC_ROWS = 3,
    parameter int ELEC_COLS = 9
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [2:0]                       i_cmd,
    input  wire  [lmfs_pkg::LMFS_IDX_W-1:0]  i_led_index,
    input  wire                              i_dot_value,
    input  wire  [lmfs_pkg::LMFS_SYM_W-1:0]  i_symbol_bits,
    output logic                             o_done,
    output logic [2:0]                       o_row_drive,
    output logic [lmfs_pkg::LMFS_COL_W-1:0]  o_col_drive
);
    import lmfs_pkg::*;

    t_state                r_state, n_state;
    logic [2:0]            r_cmd, n_cmd;
    logic [LMFS_IDX_W-1:0] r_idx, n_idx;
    logic                  r_val, n_val;
    logic [LMFS_SYM_W-1:0] r_sym, n_sym;
    logic [1:0]            r_step, n_step;
    logic [LMFS_LED_W-1:0] r_cnt, n_cnt;
    logic [LMFS_ROW_W-1:0] r_scan, n_scan;
    logic                  r_active, n_active;
    logic [LMFS_COL_W-1:0] r_col, n_col;
    logic                  r_done, n_done;

    t_frame_op             w_op;
    logic [LMFS_LED_W-1:0] w_led;
    logic [LMFS_IDX_W-1:0] w_k;
    logic [LMFS_ROW_W-1:0] w_next_scan;
    logic [ELEC_COLS-1:0]  w_rd_data;

    lmfs_frame #(
        .ELEC_ROWS(ELEC_ROWS),
        .ELEC_COLS(ELEC_COLS)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_rd_row  (w_next_scan),
        .o_rd_data (w_rd_data)
    );

    assign w_led       = (r_state == ST_SYM) ? r_cnt : r_idx[LMFS_LED_W-1:0];
    assign w_k         = mod_step_k(r_step);
    assign w_next_scan = (r_scan == LMFS_ROW_W'(ELEC_ROWS - 1)) ? '0 : r_scan + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_scan   <= '0;
            r_active <= 1'b0;
            r_col    <= '1;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_active <= n_active;
            r_col    <= n_col;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_sym  <= n_sym;
        r_step <= n_step;
        r_cnt  <= n_cnt;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_val    = r_val;
        n_sym    = r_sym;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_scan   = r_scan;
        n_active = r_active;
        n_col    = r_col;
        n_done   = 1'b0;

        w_op.clear_all = 1'b0;
        w_op.wr_en     = 1'b0;
        w_op.lit       = 1'b1;
        w_op.row       = led_row(w_led);
        w_op.mask      = led_mask(w_led);

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd  = i_cmd;
                    n_idx  = i_led_index;
                    n_val  = i_dot_value;
                    n_sym  = i_symbol_bits;
                    n_step = '0;
                    if (i_cmd == CMD_DOT_ON || i_cmd == CMD_DOT_OFF
                            || i_cmd == CMD_DOT_SET) begin
                        n_state = ST_MOD;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_MOD: begin
                if (r_idx >= w_k) begin
                    n_idx = r_idx - w_k;
                end
                n_step = r_step + 1'b1;
                if (r_step == 2'd3) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_REPLY;
                case (r_cmd)
                    CMD_DOT_ON: begin
                        w_op.wr_en = 1'b1;
                    end
                    CMD_DOT_OFF: begin
                        w_op.wr_en = 1'b1;
                        w_op.lit   = 1'b0;
                    end
                    CMD_DOT_SET: begin
                        w_op.wr_en = 1'b1;
                        w_op.lit   = r_val;
                    end
                    CMD_CLEAR: begin
                        w_op.clear_all = 1'b1;
                    end
                    CMD_LOAD: begin
                        w_op.clear_all = 1'b1;
                        n_cnt          = '0;
                        n_state        = ST_SYM;
                    end
                    CMD_TICK: begin
                        n_scan   = w_next_scan;
                        n_active = 1'b1;
                        n_col    = ~LMFS_COL_W'(w_rd_data);
                    end
                    default: begin
                    end
                endcase
            end
            ST_SYM: begin
                w_op.wr_en = r_sym[0];
                n_sym      = r_sym >> 1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LMFS_LED_W'(LMFS_LED_COUNT - 1)) begin
                    n_state = ST_REPLY;
                end
            end
            ST_REPLY: begin
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_row_drive = r_active ? (3'b001 << r_scan) : 3'b000;
    assign o_col_drive = r_col;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_row_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_row_drive))
        else $error("more than one row driven");

    a_idx_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && (r_cmd == CMD_DOT_ON || r_cmd == CMD_DOT_OFF
            || r_cmd == CMD_DOT_SET)) |-> (r_idx < LMFS_IDX_W'(LMFS_LED_COUNT)))
        else $error("LED index not reduced below 25");

endmodule

`default_nettype wire
